// ===== rtl/set_assoc_cache_lookup_assert.svh =====
// Assertion macros for the cache lookup block.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef SET_ASSOC_CACHE_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define SCL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cache lookup check failed");
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache lookup check failed");
`else
`define SCL_ASSERT_NOW(label, clk, rst, ante, cons)
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/scl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scl_pkg;
   localparam int ADDR_BITS  = 24;
   localparam int MAX_WAYS   = 16;
   localparam int WAY_W      = 4;
   localparam int CNT_W      = 5;
   localparam int SET_W      = 10;
   localparam int BLOCK_W    = 20;
   localparam int TAG_W      = 20;
   localparam int RANK_W     = 4;
   localparam int ENT_AW     = SET_W + WAY_W;
   localparam int ENT_DEPTH  = 1 << ENT_AW;
   localparam int SEEN_W     = 64;
   localparam int SEEN_BIT_W = 6;
   localparam int SEEN_AW    = BLOCK_W - SEEN_BIT_W;
   localparam int SEEN_DEPTH = 1 << SEEN_AW;
   localparam int CLR_W      = 14;
   localparam int LFSR_W     = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;

   localparam logic [2:0] CSR_OFFSET_BITS = 3'd0;
   localparam logic [2:0] CSR_SET_BITS    = 3'd1;
   localparam logic [2:0] CSR_WAYS_USED   = 3'd2;
   localparam logic [2:0] CSR_POLICY      = 3'd3;

   localparam logic POLICY_RANDOM = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_RAND,
      ST_LOAD,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [RANK_W-1:0] rank;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             clear;
      logic             valid;
      logic [WAY_W-1:0] way;
      logic [TAG_W-1:0] tag;
   } scan_ctrl_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic             inv;
      logic [WAY_W-1:0] inv_way;
      logic [WAY_W-1:0] lru_way;
   } scan_status_type;

   typedef struct packed {
      logic             done;
      logic [WAY_W-1:0] way;
   } vic_status_type;
endpackage
`default_nettype wire

// ===== rtl/scl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/scl_way_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scl_way_scan import scl_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire scan_ctrl_type   ctrl,
   input  wire entry_type       entry,
   output scan_status_type      status
);
   logic             hit_ff, hit_in, inv_ff, inv_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in, inv_way_ff, inv_way_in;
   logic [WAY_W-1:0] lru_way_ff, lru_way_in;
   logic [RANK_W-1:0] best_ff, best_in;

   // Compare one way per cycle: first valid match, first invalid, lowest oldest.
   always_comb begin
      hit_in     = hit_ff;
      hit_way_in = hit_way_ff;
      inv_in     = inv_ff;
      inv_way_in = inv_way_ff;
      lru_way_in = lru_way_ff;
      best_in    = best_ff;
      if (ctrl.clear) begin
         hit_in  = 1'b0;
         inv_in  = 1'b0;
         best_in = '0;
      end else if (ctrl.valid) begin
         if (entry.valid && entry.tag == ctrl.tag && !hit_ff) begin
            hit_in     = 1'b1;
            hit_way_in = ctrl.way;
         end
         if (!entry.valid && !inv_ff) begin
            inv_in     = 1'b1;
            inv_way_in = ctrl.way;
         end
         if (ctrl.way == '0 || entry.rank > best_ff) begin
            best_in    = entry.rank;
            lru_way_in = ctrl.way;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         inv_ff  <= 1'b0;
         best_ff <= '0;
      end else begin
         hit_ff  <= hit_in;
         inv_ff  <= inv_in;
         best_ff <= best_in;
      end
      hit_way_ff <= hit_way_in;
      inv_way_ff <= inv_way_in;
      lru_way_ff <= lru_way_in;
   end

   assign status.hit     = hit_ff;
   assign status.hit_way = hit_way_ff;
   assign status.inv     = inv_ff;
   assign status.inv_way = inv_way_ff;
   assign status.lru_way = lru_way_ff;
endmodule
`default_nettype wire

// ===== rtl/scl_victim_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scl_victim_unit import scl_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CNT_W-1:0] nways,
   output vic_status_type        status
);
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in, div_ff, div_in, lfsr_next;
   logic [CNT_W-1:0]  rem_ff, rem_in, step_ff, step_in, rem_s;
   logic              busy_ff, busy_in, done_ff, done_in;

   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[LFSR_W-1:1]};

   // Step the LFSR, then take the remainder by the way count one bit a cycle.
   always_comb begin
      lfsr_in = lfsr_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_s   = {rem_ff[CNT_W-2:0], div_ff[LFSR_W-1]};
      if (rem_s >= nways) begin
         rem_s = rem_s - nways;
      end
      if (start) begin
         lfsr_in = lfsr_next;
         div_in  = lfsr_next;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = rem_s;
         div_in  = {div_ff[LFSR_W-2:0], 1'b0};
         step_in = step_ff + CNT_W'(1);
         if (step_ff == CNT_W'(LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         lfsr_ff <= lfsr_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign status.done = done_ff;
   assign status.way  = rem_ff[WAY_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_lookup.sv =====
// Set-associative cache lookup with LRU or random replacement.
// req channel: one access per request; req_tdata carries the byte address,
// req_tuser the access kind (0 read, 1 write).
// rsp channel: one result per request in rsp_tdata (hit, first touch,
// dirty eviction, way used).
// csr channel: register writes (0 offset_bits, 1 set_bits, 2 ways_used,
// 3 policy); write only while no request is in flight.
// Each request reads the ways of the set one a cycle from the tag RAM's
// single read port through the shared compare unit, then writes them back
// one a cycle. A random eviction also waits for the LFSR remainder unit.
// One request is in work at a time; req_tready is high only when idle.
// Reset: the tag and seen-block RAMs are swept to zero, one row a cycle;
// requests are held off meanwhile, csr writes are taken.
// A stalled rsp keeps its result in the output register; the block holds
// the next finished result until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_lookup_assert.svh"
module set_assoc_cache_lookup import scl_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ADDR_BITS-1:0] req_tdata,   // [23:0] address
   input  wire logic                 req_tuser,   // [0] op
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,   // [0] hit, [1] first_touch,
                                                  // [2] dirty_evict, [6:3] way_used
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [2:0]           csr_index,
   input  wire logic [4:0]           csr_data
);
   state_type state_ff, state_in;

   logic [3:0] offset_bits_ff, set_bits_ff;
   logic [4:0] ways_used_ff;
   logic       policy_ff;

   logic [3:0]       off_eff, sb_eff;
   logic [CNT_W-1:0] nways;
   logic [BLOCK_W-1:0] block;
   logic [SET_W-1:0]   set_mask;

   logic               op_ff, op_in;
   logic [SET_W-1:0]   set_ff, set_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [SEEN_BIT_W-1:0] bit_ff, bit_in;
   logic [SEEN_AW-1:0] row_ff, row_in;
   logic               chk_ff, chk_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               dv_ff, dv_in;
   logic [WAY_W-1:0]   dw_ff, dw_in;
   logic               first_ff, first_in;
   logic [WAY_W-1:0]   w_ff, w_in;
   logic [RANK_W-1:0]  r_ff, r_in;
   logic               wasv_ff, wasv_in, devict_ff, devict_in, hit_ff, hit_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;

   entry_type line_ff [MAX_WAYS];
   entry_type line_sel, ent_new, ent_rdata;
   logic [WAY_W-1:0] line_idx;

   logic               ent_wr, ent_rd;
   logic [ENT_AW-1:0]  ent_waddr, ent_raddr;
   logic [ENTRY_W-1:0] ent_wdata, ent_rdata_raw;
   logic               seen_wr, seen_rd;
   logic [SEEN_AW-1:0] seen_waddr;
   logic [SEEN_W-1:0]  seen_wdata, seen_rdata;

   scan_ctrl_type   scan_ctrl;
   scan_status_type scan_st;
   logic            vic_start;
   vic_status_type  vic_st;
   logic            accept;

   // Clamp configuration to the supported ranges.
   always_comb begin
      off_eff = offset_bits_ff;
      if (offset_bits_ff < 4'd4)  off_eff = 4'd4;
      if (offset_bits_ff > 4'd12) off_eff = 4'd12;
      sb_eff = (set_bits_ff > 4'(SET_W)) ? 4'(SET_W) : set_bits_ff;
      nways  = ways_used_ff;
      if (ways_used_ff == '0) nways = CNT_W'(1);
      if (ways_used_ff > CNT_W'(MAX_WAYS)) nways = CNT_W'(MAX_WAYS);
      block    = BLOCK_W'(req_tdata >> off_eff);
      set_mask = SET_W'((11'd1 << sb_eff) - 11'd1);
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   assign line_idx  = (state_ff == ST_LOAD) ? w_ff : cnt_ff[WAY_W-1:0];
   assign line_sel  = line_ff[line_idx];
   assign ent_rdata = entry_type'(ent_rdata_raw);

   // Updated entry for the way under write-back.
   always_comb begin
      ent_new = line_sel;
      if (cnt_ff[WAY_W-1:0] == w_ff) begin
         ent_new.valid = 1'b1;
         ent_new.rank  = '0;
         if (hit_ff) begin
            ent_new.dirty = line_sel.dirty | op_ff;
         end else begin
            ent_new.dirty = op_ff;
            ent_new.tag   = tag_ff;
         end
      end else if (line_sel.valid && (!wasv_ff || line_sel.rank < r_ff)
                   && line_sel.rank < RANK_MAX) begin
         ent_new.rank = line_sel.rank + RANK_W'(1);
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      bit_in       = bit_ff;
      row_in       = row_ff;
      chk_in       = 1'b0;
      cnt_in       = cnt_ff;
      dv_in        = 1'b0;
      dw_in        = dw_ff;
      first_in     = first_ff;
      w_in         = w_ff;
      r_in         = r_ff;
      wasv_in      = wasv_ff;
      devict_in    = devict_ff;
      hit_in       = hit_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ent_wr       = 1'b0;
      ent_waddr    = {set_ff, cnt_ff[WAY_W-1:0]};
      ent_wdata    = ENTRY_W'(ent_new);
      ent_rd       = 1'b0;
      ent_raddr    = {set_ff, cnt_ff[WAY_W-1:0]};
      seen_wr      = 1'b0;
      seen_waddr   = row_ff;
      seen_wdata   = seen_rdata | (SEEN_W'(1) << bit_ff);
      seen_rd      = 1'b0;
      vic_start    = 1'b0;
      scan_ctrl.clear = 1'b0;
      scan_ctrl.valid = dv_ff;
      scan_ctrl.way   = dw_ff;
      scan_ctrl.tag   = tag_ff;
      case (state_ff)
         ST_CLEAR: begin
            // Sweep both RAMs to zero.
            ent_wr     = 1'b1;
            ent_waddr  = ENT_AW'(clr_ff);
            ent_wdata  = '0;
            seen_wr    = 1'b1;
            seen_waddr = SEEN_AW'(clr_ff);
            seen_wdata = '0;
            clr_in     = clr_ff + CLR_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               set_in   = block[SET_W-1:0] & set_mask;
               tag_in   = TAG_W'(block >> sb_eff);
               bit_in   = block[SEEN_BIT_W-1:0];
               row_in   = block[BLOCK_W-1:SEEN_BIT_W];
               seen_rd  = 1'b1;
               chk_in   = 1'b1;
               cnt_in   = '0;
               scan_ctrl.clear = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chk_ff) begin
               // Seen row arrived: flag first touch, mark the block seen.
               first_in = !seen_rdata[bit_ff];
               seen_wr  = 1'b1;
            end
            if (cnt_ff < nways) begin
               ent_rd = 1'b1;
               dv_in  = 1'b1;
               dw_in  = cnt_ff[WAY_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (!dv_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            hit_in   = scan_st.hit;
            state_in = ST_LOAD;
            if (scan_st.hit) begin
               w_in = scan_st.hit_way;
            end else if (scan_st.inv) begin
               w_in = scan_st.inv_way;
            end else if (policy_ff == POLICY_RANDOM) begin
               vic_start = 1'b1;
               state_in  = ST_RAND;
            end else begin
               w_in = scan_st.lru_way;
            end
         end
         ST_RAND: begin
            if (vic_st.done) begin
               w_in     = vic_st.way;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            r_in      = line_sel.rank;
            wasv_in   = line_sel.valid;
            devict_in = !hit_ff && line_sel.valid && line_sel.dirty;
            cnt_in    = '0;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            ent_wr = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == nways - CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, w_ff, devict_ff, first_ff, hit_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         chk_ff         <= 1'b0;
         dv_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         offset_bits_ff <= 4'd6;
         set_bits_ff    <= 4'd0;
         ways_used_ff   <= 5'd16;
         policy_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_ff       <= chk_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OFFSET_BITS: offset_bits_ff <= csr_data[3:0];
               CSR_SET_BITS:    set_bits_ff    <= csr_data[3:0];
               CSR_WAYS_USED:   ways_used_ff   <= csr_data;
               CSR_POLICY:      policy_ff      <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
      op_ff       <= op_in;
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      bit_ff      <= bit_in;
      row_ff      <= row_in;
      cnt_ff      <= cnt_in;
      dw_ff       <= dw_in;
      first_ff    <= first_in;
      w_ff        <= w_in;
      r_ff        <= r_in;
      wasv_ff     <= wasv_in;
      devict_ff   <= devict_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
      // Keep a copy of the set's ways for the write-back pass.
      if (dv_ff) begin
         line_ff[dw_ff] <= ent_rdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   scl_ram #(.WIDTH(ENTRY_W), .DEPTH(ENT_DEPTH)) u_tag_ram (
      .clock   (clock),
      .wr_en   (ent_wr),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_rd),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata_raw)
   );

   scl_ram #(.WIDTH(SEEN_W), .DEPTH(SEEN_DEPTH)) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr),
      .wr_addr (seen_waddr),
      .wr_data (seen_wdata),
      .rd_en   (seen_rd),
      .rd_addr (block[BLOCK_W-1:SEEN_BIT_W]),
      .rd_data (seen_rdata)
   );

   scl_way_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (scan_ctrl),
      .entry  (ent_rdata),
      .status (scan_st)
   );

   scl_victim_unit u_victim (
      .clock  (clock),
      .reset  (reset),
      .start  (vic_start),
      .nways  (nways),
      .status (vic_st)
   );

   `SCL_ASSERT_NOW(a_way_in_range, clock, reset, state_ff == ST_LOAD, w_ff < nways)
   `SCL_ASSERT_NOW(a_scan_complete, clock, reset, state_ff == ST_PICK, cnt_ff == nways)
   `SCL_ASSERT_NEXT(a_rand_done, clock, reset, vic_st.done, state_ff == ST_LOAD)
endmodule
`default_nettype wire

// ===== tb/sv/tb_set_assoc_cache_lookup.sv =====
`timescale 1ns / 1ps
module tb_set_assoc_cache_lookup;
   import scl_pkg::*;

   localparam int SEEN_BLOCKS = 1 << 20;

   typedef struct packed {
      logic             hit;
      logic             first_touch;
      logic             dirty_evict;
      logic [WAY_W-1:0] way_used;
   } lookup_result_type;

   // Cache shadow: tracks tags, ranks and the seen-block map alongside the block.
   class cache_scoreboard;
      logic [3:0]        offset_cfg, set_cfg;
      logic [4:0]        ways_cfg;
      logic              policy_cfg;
      logic [TAG_W-1:0]  tags  [ENT_DEPTH];
      bit                valid [ENT_DEPTH];
      bit                dirty [ENT_DEPTH];
      logic [RANK_W-1:0] ranks [ENT_DEPTH];
      bit                seen  [SEEN_BLOCKS];
      logic [LFSR_W-1:0] lfsr;
      lookup_result_type pending[$];
      int                errors;

      function new();
         offset_cfg = 6; set_cfg = 0; ways_cfg = 16; policy_cfg = 1;
         lfsr = LFSR_SEED;
         errors = 0;
         foreach (valid[i]) begin
            valid[i] = 0; dirty[i] = 0; ranks[i] = 0; tags[i] = '0;
         end
         foreach (seen[i]) seen[i] = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [4:0] val);
         case (idx)
            CSR_OFFSET_BITS: offset_cfg = val[3:0];
            CSR_SET_BITS:    set_cfg    = val[3:0];
            CSR_WAYS_USED:   ways_cfg   = val;
            CSR_POLICY:      policy_cfg = val[0];
            default: ;
         endcase
      endfunction

      function void promote(int base, int nways, int w, bit was_valid);
         logic [RANK_W-1:0] r;
         r = ranks[base + w];
         for (int i = 0; i < nways; i++) begin
            if (i == w || !valid[base + i]) continue;
            if ((!was_valid || ranks[base + i] < r) && ranks[base + i] != RANK_MAX)
               ranks[base + i]++;
         end
         ranks[base + w] = 0;
      endfunction

      // Note an accepted request and queue its expected result.
      function void note_access(bit op, logic [ADDR_BITS-1:0] addr);
         int off, sb, nways, base, w, sidx;
         logic [ADDR_BITS-1:0] block;
         logic [TAG_W-1:0] tag;
         lookup_result_type res;
         bit found, wasv;
         logic [RANK_W-1:0] best;
         off = offset_cfg; sb = set_cfg; nways = ways_cfg;
         if (off < 4) off = 4;
         if (off > 12) off = 12;
         while (sb > SET_W) sb--;
         if (nways < 1) nways = 1;
         if (nways > MAX_WAYS) nways = MAX_WAYS;
         block = addr >> off;
         base = int'(block & ((1 << sb) - 1)) * MAX_WAYS;
         tag = TAG_W'(block >> sb);
         sidx = int'(block) % SEEN_BLOCKS;
         res = '0;
         res.first_touch = !seen[sidx];
         seen[sidx] = 1;
         w = 0; found = 0; wasv = 0;
         for (int i = 0; i < nways; i++)
            if (valid[base + i] && tags[base + i] == tag) begin
               w = i; res.hit = 1; break;
            end
         if (res.hit) begin
            promote(base, nways, w, 1);
            if (op) dirty[base + w] = 1;
         end else begin
            for (int i = 0; i < nways; i++)
               if (!valid[base + i]) begin
                  w = i; found = 1; break;
               end
            if (!found) begin
               if (policy_cfg == POLICY_RANDOM) begin
                  lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                  w = int'(lfsr) % nways;
               end else begin
                  best = ranks[base];
                  w = 0;
                  for (int i = 1; i < nways; i++)
                     if (ranks[base + i] > best) begin
                        best = ranks[base + i]; w = i;
                     end
               end
               wasv = valid[base + w];
               res.dirty_evict = wasv && dirty[base + w];
            end
            promote(base, nways, w, wasv);
            tags[base + w] = tag;
            valid[base + w] = 1;
            dirty[base + w] = op;
         end
         res.way_used = WAY_W'(w);
         pending.push_back(res);
      endfunction

      task automatic report(string what, int got, int want);
         errors++;
         $display("mismatch %s: got %0d expected %0d", what, got, want);
      endtask

      task automatic check_result(logic [7:0] data);
         lookup_result_type want;
         if (pending.size() == 0) begin
            report("unexpected response", data, 0);
            return;
         end
         want = pending.pop_front();
         if (data[0] !== want.hit) report("hit", data[0], want.hit);
         if (data[1] !== want.first_touch) report("first_touch", data[1], want.first_touch);
         if (data[2] !== want.dirty_evict) report("dirty_evict", data[2], want.dirty_evict);
         if (data[6:3] !== want.way_used) report("way_used", data[6:3], want.way_used);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tuser = 0;
   logic [ADDR_BITS-1:0] req_tdata = '0;
   logic req_tready;
   logic rsp_tvalid, rsp_tready = 0;
   logic [7:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [4:0] csr_data = '0;
   bit stim_done = 0;
   int cycles = 0;

   cache_scoreboard board = new();

   always #6 clock = ~clock;

   set_assoc_cache_lookup dut (.*);

   // Generous bound: clearing sweep plus ~800 requests at worst-case latency and stalls.
   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Check responses at the rising edge; toggle ready at the falling edge.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);

   initial begin
      int g;
      @(negedge clock);
      while (1) begin
         g = gap_len();
         rsp_tready <= (g == 0);
         repeat (g == 0 ? $urandom_range(1, 8) : g) @(negedge clock);
      end
   end

   // Hold csr_valid across back-to-back writes; the caller drops it at the end.
   task automatic write_csr(logic [2:0] idx, logic [4:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic send_access(bit op, logic [ADDR_BITS-1:0] addr);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= addr;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      board.note_access(op, addr);
      @(negedge clock);
   endtask

   // Drain outstanding responses, then let the block settle before a config change.
   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic configure(int off, int sb, int nw, int pol);
      drain();
      write_csr(CSR_OFFSET_BITS, 5'(off));
      write_csr(CSR_SET_BITS, 5'(sb));
      write_csr(CSR_WAYS_USED, 5'(nw));
      write_csr(CSR_POLICY, 5'(pol));
      write_csr(3'd5, 5'd31);   // out-of-range index: ignored
      csr_valid <= 0;
   endtask

   // Addresses drawn mostly from a small pool of blocks to force reuse and eviction.
   task automatic random_phase(int n, int pool);
      logic [ADDR_BITS-1:0] a;
      int off;
      off = board.offset_cfg < 4 ? 4 : (board.offset_cfg > 12 ? 12 : board.offset_cfg);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            a = ADDR_BITS'($urandom);
         else
            a = (ADDR_BITS'($urandom_range(0, pool - 1)) * ADDR_BITS'(1 << off))
                ^ ADDR_BITS'($urandom_range(0, (1 << off) - 1))
                ^ (ADDR_BITS'($urandom_range(0, 3)) << 22);
         send_access(1'($urandom_range(0, 1)), a);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset config (fully associative, 16 ways, LRU).
      send_access(0, 24'h000000);
      send_access(1, 24'hFFFFFF);
      send_access(0, 24'h000010);   // same block, hit
      send_access(1, 24'h000000);   // write hit, mark dirty
      for (int i = 1; i <= 17; i++) send_access(i[0], ADDR_BITS'(i) << 6);   // fill, evict
      // Extremes: clamped offset and sets, zero and oversize ways, random policy.
      configure(0, 15, 0, 0);
      send_access(1, 24'h123450);
      send_access(0, 24'h923450);
      send_access(0, 24'h000000);
      configure(15, 10, 31, 0);
      send_access(1, 24'hABCDEF);
      send_access(0, 24'h5BCDEF);

      configure(4, 2, 4, 1);   random_phase(150, 40);
      configure(6, 0, 16, 0);  random_phase(120, 40);
      configure(12, 10, 1, 1); random_phase(100, 1500);
      configure(5, 3, 2, 0);   random_phase(130, 30);
      configure(7, 1, 8, 1);   random_phase(130, 48);
      configure(9, 4, 3, 0);   random_phase(120, 100);
      drain();
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
